// ===== src/crcfe_pkg.sv =====
// ----------------------------------------------------------------------------
// crcfe_pkg
// Shared types, constants and the CRC-16 byte update for the command
// frame encoder.
// ----------------------------------------------------------------------------
package crcfe_pkg;

    // Frame constants
    localparam logic [7:0] SYNC_LO   = 8'h55;
    localparam logic [7:0] SYNC_HI   = 8'h66;
    localparam logic [7:0] CTRL_BYTE = 8'h01;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [9:0] MAX_PAYLOAD = 10'd1023;

    // Header length in bytes, command queue depth and queue pointer width
    localparam logic [3:0] HDR_LEN = 4'd8;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Request types on the input channel
    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_PAYLOAD = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DROP    = 2'd1;
    localparam logic [1:0] ST_ABANDON = 2'd2;

    // Classified command kinds
    typedef enum logic [1:0] {
        K_START   = 2'd0,
        K_PAYLOAD = 2'd1,
        K_STRAY   = 2'd2
    } kind_t;

    // Work item passed from the front end to the byte serializer
    typedef struct packed {
        kind_t       kind;
        logic [1:0]  status;
        logic [7:0]  data;       // cmd_id on start, payload byte otherwise
        logic [9:0]  len;        // saturated length (start only)
        logic [15:0] seq;        // sequence number (start only)
        logic        crc_after;  // append CRC after this item's data bytes
    } cmd_t;

    // CRC-16, poly 0x1021, MSB first, one byte
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== src/crcfe_ifs.sv =====
// ----------------------------------------------------------------------------
// crcfe_ifs
// Valid/ready channel interfaces for request items and frame bytes.
// ----------------------------------------------------------------------------

// Request channel
interface crcfe_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] cmd_id;
    logic [9:0] payload_len;
    logic [7:0] payload_byte;

    modport source (output valid, req_type, cmd_id, payload_len, payload_byte,
                    input ready);
    modport sink (input valid, req_type, cmd_id, payload_len, payload_byte,
                  output ready);
endinterface

// Frame byte channel
interface crcfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
    logic [1:0] status;

    modport source (output valid, out_byte, run_last, frame_end, status,
                    input ready);
    modport sink (input valid, out_byte, run_last, frame_end, status,
                  output ready);
endinterface

// ===== src/crcfe_front.sv =====
// ----------------------------------------------------------------------------
// crcfe_front
// Accepts request items, tracks frame state (sequence, bytes left, open
// flag) and classifies each item into a command for the serializer.
// ----------------------------------------------------------------------------
module crcfe_front
    import crcfe_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    crcfe_in_if.sink in,
    input  logic   q_full,
    output logic   q_push,
    output cmd_t   q_cmd
);

    logic        frame_open_reg, frame_open_next;
    logic [9:0]  bytes_left_reg, bytes_left_next;
    logic [15:0] seq_reg, seq_next;
    logic [9:0]  len_sat;
    logic        xfer;

    assign in.ready = !q_full;
    assign xfer     = in.valid && in.ready;
    assign q_push   = xfer;

    // Saturate requested length
    assign len_sat = (in.payload_len > MAX_PAYLOAD) ? MAX_PAYLOAD : in.payload_len;

    // Classify and compute next frame state
    always_comb
    begin
        frame_open_next = frame_open_reg;
        bytes_left_next = bytes_left_reg;
        seq_next        = seq_reg;
        q_cmd           = '0;
        q_cmd.data      = in.payload_byte;
        q_cmd.len       = len_sat;
        if (in.req_type == REQ_START)
        begin
            seq_next        = seq_reg + 16'd1;
            q_cmd.kind      = K_START;
            q_cmd.status    = frame_open_reg ? ST_ABANDON : ST_OK;
            q_cmd.data      = in.cmd_id;
            q_cmd.seq       = seq_next;
            q_cmd.crc_after = (len_sat == 10'd0);
            frame_open_next = (len_sat != 10'd0);
            bytes_left_next = len_sat;
        end
        else if (frame_open_reg)
        begin
            q_cmd.kind      = K_PAYLOAD;
            q_cmd.status    = ST_OK;
            q_cmd.crc_after = (bytes_left_reg == 10'd1);
            bytes_left_next = bytes_left_reg - 10'd1;
            frame_open_next = (bytes_left_reg != 10'd1);
        end
        else
        begin
            q_cmd.kind   = K_STRAY;
            q_cmd.status = ST_DROP;
        end
    end

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            bytes_left_reg <= '0;
            seq_reg        <= '0;
        end
        else if (xfer)
        begin
            frame_open_reg <= frame_open_next;
            bytes_left_reg <= bytes_left_next;
            seq_reg        <= seq_next;
        end
    end

endmodule

// ===== src/crcfe_queue.sv =====
// ----------------------------------------------------------------------------
// crcfe_queue
// Small FIFO of classified commands between front end and serializer.
// ----------------------------------------------------------------------------
module crcfe_queue
    import crcfe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t                mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                do_push, do_pop;

    assign full       = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Front end never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");

    // Occupancy never exceeds depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W+1)'(QDEPTH))
        else $error("queue count out of range");

    // Pointer spacing matches occupancy
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[QPTR_W-1:0])
        else $error("queue pointers disagree with count");

endmodule

// ===== src/crcfe_back.sv =====
// ----------------------------------------------------------------------------
// crcfe_back
// Serializes queued commands into frame bytes, one per cycle while a command is
// queued and out.ready is high, keeping the running CRC and driving the registered output channel.
// ----------------------------------------------------------------------------
module crcfe_back
    import crcfe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic head_valid,
    input  cmd_t head_cmd,
    output logic pop,
    crcfe_out_if.source out
);

    logic [3:0]  idx_reg;
    logic [15:0] crc_reg;
    logic [15:0] crc_base, crc_next;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        run_last_reg, frame_end_reg;
    logic [1:0]  status_reg;

    logic        is_start;
    logic [3:0]  n_data;
    logic [3:0]  total;
    logic        is_data;
    logic        is_last;
    logic        cur_fend;
    logic [7:0]  cur_byte;
    logic [7:0]  hdr_byte;
    logic        load;

    assign is_start = (head_cmd.kind == K_START);
    assign n_data   = is_start ? HDR_LEN : 4'd1;
    assign total    = n_data + ((head_cmd.crc_after && head_cmd.kind != K_STRAY) ? 4'd2 : 4'd0);
    assign is_last  = (idx_reg == total - 4'd1);
    assign is_data  = (idx_reg < n_data) && (head_cmd.kind != K_STRAY);

    // Header byte by position
    always_comb
    begin
        case (idx_reg[2:0])
            3'd0:    hdr_byte = SYNC_LO;
            3'd1:    hdr_byte = SYNC_HI;
            3'd2:    hdr_byte = CTRL_BYTE;
            3'd3:    hdr_byte = head_cmd.len[7:0];
            3'd4:    hdr_byte = {6'b0, head_cmd.len[9:8]};
            3'd5:    hdr_byte = head_cmd.seq[7:0];
            3'd6:    hdr_byte = head_cmd.seq[15:8];
            default: hdr_byte = head_cmd.data;
        endcase
    end

    // Current byte select
    always_comb
    begin
        cur_fend = 1'b0;
        if (idx_reg < n_data)
        begin
            case (head_cmd.kind)
                K_START:   cur_byte = hdr_byte;
                K_PAYLOAD: cur_byte = head_cmd.data;
                default:   cur_byte = 8'h00;
            endcase
        end
        else if (idx_reg == n_data)
            cur_byte = crc_reg[7:0];
        else
        begin
            cur_byte = crc_reg[15:8];
            cur_fend = 1'b1;
        end
    end

    // CRC restarts at the first header byte
    assign crc_base = (is_start && idx_reg == 4'd0) ? 16'h0000 : crc_reg;
    assign crc_next = crc_feed(crc_base, cur_byte);

    assign load = head_valid && (!out_valid_reg || out.ready);
    assign pop  = load && is_last;

    // Serializer position and CRC
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            crc_reg <= '0;
        end
        else if (load)
        begin
            idx_reg <= is_last ? 4'd0 : idx_reg + 4'd1;
            if (is_data)
                crc_reg <= crc_next;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (out.ready)
            out_valid_reg <= 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg  <= cur_byte;
            run_last_reg  <= is_last;
            frame_end_reg <= cur_fend;
            status_reg    <= head_cmd.status;
        end
    end

    assign out.valid     = out_valid_reg;
    assign out.out_byte  = out_byte_reg;
    assign out.run_last  = run_last_reg;
    assign out.frame_end = frame_end_reg;
    assign out.status    = status_reg;

    // Final CRC byte always closes the item's run
    a_fend_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && frame_end_reg |-> run_last_reg)
        else $error("frame_end without run_last");

    // Position stays inside the current command
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> idx_reg < total)
        else $error("serializer position past command end");

    // Position returns to zero after a pop
    a_idx_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> idx_reg == 4'd0)
        else $error("serializer position not reset after pop");

endmodule

// ===== src/crc16_command_frame_encoder.sv =====
// A request transfer is written into the command queue; the serializer then loads its byte
// into the output register and raises output valid, and the byte transfers when out.ready is high.
// Throughput: one request per cycle while the 4-entry command queue has room; output
// bytes leave one per cycle while out.ready is high. A start item emits 8 or 10 bytes,
// the payload item that closes a frame 3 and any other item 1.
// Reset (rst_n low, asynchronous) clears the sequence counter, frame state, queue and
// output valid; the first frame after reset carries sequence number 1.
// ----------------------------------------------------------------------------
// crc16_command_frame_encoder
// Command frame builder: header, payload bytes and trailing CRC-16.
// ----------------------------------------------------------------------------
module crc16_command_frame_encoder
    import crcfe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    crcfe_in_if.sink     in,
    crcfe_out_if.source  out
);

    logic q_push, q_full, q_pop, q_head_valid;
    cmd_t q_push_cmd, q_head_cmd;

    // Request classification and frame state
    crcfe_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in     (in),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (q_push_cmd)
    );

    // Command queue
    crcfe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    // Byte serializer and CRC
    crcfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd),
        .pop        (q_pop),
        .out        (out)
    );

endmodule
